// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SRRW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SRRW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/srrw_pkg.sv =====
// types, codes and defaults for the selective repeat receive window
// no dependencies
package srrw_pkg;

    localparam int WINDOW_DEF   = 4;
    localparam int SEQ_BITS_DEF = 16;

    // result status codes
    localparam logic [1:0] ST_NEW = 2'd0;
    localparam logic [1:0] ST_DUP = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    typedef struct packed {
        logic        [15:0] seq_number;
        logic signed [31:0] payload;
    } pkt_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        ack_valid;
        logic [15:0] ack_seq;
        logic [15:0] window_base;
    } res_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SLIDE
    } state_t;

endpackage

// ===== hw/rtl/selective_repeat_receive_window.sv =====
// top level of the selective repeat receive window
// depends on srrw_pkg, srrw_ctrl, srrw_dp and assert_macros.svh
//
//   channel | signals                    | beat
//   --------+----------------------------+---------------------------------------
//   pkt     | pkt_valid, pkt_ready, pkt  | seq_number, payload
//   res     | res_valid, res_ready, res  | status, ack_valid, ack_seq, window_base
//
// a packet is handled in the eval state, which tests the window and sets its mark,
// then in the slide state, which slides the window past the run of received marks
// and loads the result register; the next packet is taken in the cycle the result
// register loads, so a new beat is not taken before the last one is through
// reset clears the marks, base and ring head at once; the payload store is not cleared
// a stalled result holds in its register; the slide waits until that register frees
module selective_repeat_receive_window #(
    parameter int WINDOW   = srrw_pkg::WINDOW_DEF,
    parameter int SEQ_BITS = srrw_pkg::SEQ_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pkt_valid,
    output logic           pkt_ready,
    input  srrw_pkg::pkt_t pkt,
    output logic           res_valid,
    input  logic           res_ready,
    output srrw_pkg::res_t res
);
    import srrw_pkg::*;

    // commands from the sequencer
    cmd_t cmd;

    // handshakes and sequencing
    srrw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cmd       (cmd)
    );

    // window state, payload store and result register
    srrw_dp #(
        .WINDOW   (WINDOW),
        .SEQ_BITS (SEQ_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .cmd   (cmd),
        .res   (res)
    );

`include "assert_macros.svh"

    // an accepted beat is always evaluated in the following cycle
    `SRRW_ASSERT_NEXT(a_accept_then_eval, pkt_valid && pkt_ready, cmd.eval, "accept not followed by eval")
    // no new beat is taken while one is being evaluated
    `SRRW_ASSERT_NOW(a_no_accept_in_eval, cmd.eval, !pkt_ready, "accept during eval")
    // a result only loads into a free output register
    `SRRW_ASSERT_NOW(a_commit_free, cmd.commit, !res_valid || res_ready, "result overwritten")
    // an ack goes out exactly when the packet was not discarded
    `SRRW_ASSERT_NOW(a_ack_status, res_valid, (res.ack_valid != (res.status == ST_OUT)) && (res.status != 2'd3), "ack and status disagree")

endmodule

// ===== hw/rtl/srrw_ctrl.sv =====
// sequencer for the receive window: handshakes and datapath commands
// depends on srrw_pkg
module srrw_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pkt_valid,
    output logic          pkt_ready,
    output logic          res_valid,
    input  logic          res_ready,
    output srrw_pkg::cmd_t cmd
);
    import srrw_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pkt_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_SLIDE;
            end
            S_SLIDE:
            begin
                if (out_free)
                begin
                    state_next = pkt_valid ? S_EVAL : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pkt_ready  = 1'b0;
        cmd.load   = 1'b0;
        cmd.eval   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                pkt_ready = 1'b1;
                cmd.load  = pkt_valid;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            S_SLIDE:
            begin
                pkt_ready  = out_free;
                cmd.commit = out_free;
                cmd.load   = out_free && pkt_valid;
            end
            default:
            begin
                pkt_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/srrw_dp.sv =====
// receive window datapath: window test, marks, payload store, slide, result register
// depends on srrw_pkg
module srrw_dp #(
    parameter int WINDOW   = srrw_pkg::WINDOW_DEF,
    parameter int SEQ_BITS = srrw_pkg::SEQ_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  srrw_pkg::pkt_t pkt,
    input  srrw_pkg::cmd_t cmd,
    output srrw_pkg::res_t res
);
    import srrw_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int CMP_W = (SEQ_BITS > CNT_W) ? SEQ_BITS : CNT_W;
    localparam int EXT_W = (SEQ_BITS > 16) ? SEQ_BITS : 16;

    logic [SEQ_BITS-1:0] seq_reg;
    logic [31:0]         val_reg;
    logic [SEQ_BITS-1:0] base_reg;
    logic [SEQ_BITS-1:0] base_next;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    logic [WINDOW-1:0]   mark_reg;
    logic [WINDOW-1:0]   mark_set;
    logic [WINDOW-1:0]   mark_slid;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic                ack_reg;
    logic                ack_next;
    res_t                res_reg;
    res_t                res_next;
    logic [31:0]         slot_mem [WINDOW];

    logic [EXT_W-1:0]    seq_in_ext;
    logic [EXT_W-1:0]    seq_out_ext;
    logic [EXT_W-1:0]    base_out_ext;
    logic [SEQ_BITS-1:0] ahead;
    logic [SEQ_BITS-1:0] behind;
    logic [CMP_W-1:0]    ahead_x;
    logic [CMP_W-1:0]    behind_x;
    logic                in_win;
    logic                prev_win;
    logic [IDX_W-1:0]    slot_off;
    logic                store_new;
    logic [IDX_W:0]      wr_sum;
    logic [IDX_W-1:0]    wr_idx;
    logic [CNT_W-1:0]    run_cnt;
    logic [CNT_W:0]      head_sum;

    // sequence bits above SEQ_BITS are dropped
    assign seq_in_ext = EXT_W'(pkt.seq_number);

    // window test on the captured packet
    assign ahead    = seq_reg - base_reg;
    assign behind   = base_reg - seq_reg;
    assign ahead_x  = CMP_W'(ahead);
    assign behind_x = CMP_W'(behind);
    assign in_win   = ahead_x < CMP_W'(WINDOW);
    assign prev_win = (behind_x != '0) && (behind_x <= CMP_W'(WINDOW));
    assign slot_off = ahead_x[IDX_W-1:0];
    assign store_new = in_win && !mark_reg[slot_off];

    // physical slot of the packet in the ring store
    always_comb
    begin
        wr_sum = {1'b0, head_reg} + {1'b0, slot_off};
        if (wr_sum >= (IDX_W+1)'(WINDOW))
        begin
            wr_sum = wr_sum - (IDX_W+1)'(WINDOW);
        end
        wr_idx = wr_sum[IDX_W-1:0];
    end

    always_comb
    begin
        mark_set = mark_reg;
        if (store_new)
        begin
            mark_set[slot_off] = 1'b1;
        end
    end

    always_comb
    begin
        priority if (in_win)
        begin
            status_next = store_new ? ST_NEW : ST_DUP;
            ack_next    = 1'b1;
        end
        else if (prev_win)
        begin
            status_next = ST_DUP;
            ack_next    = 1'b1;
        end
        else
        begin
            status_next = ST_OUT;
            ack_next    = 1'b0;
        end
    end

    // run of received marks at the low edge
    always_comb
    begin
        logic run;
        run     = 1'b1;
        run_cnt = '0;
        for (int k = 0; k < WINDOW; k++)
        begin
            if (run && mark_reg[k])
            begin
                run_cnt = run_cnt + CNT_W'(1);
            end
            else
            begin
                run = 1'b0;
            end
        end
    end

    assign mark_slid = mark_reg >> run_cnt;
    assign base_next = base_reg + SEQ_BITS'(run_cnt);

    always_comb
    begin
        head_sum = (CNT_W+1)'(head_reg) + (CNT_W+1)'(run_cnt);
        if (head_sum >= (CNT_W+1)'(WINDOW))
        begin
            head_sum = head_sum - (CNT_W+1)'(WINDOW);
        end
        head_next = head_sum[IDX_W-1:0];
    end

    assign seq_out_ext  = EXT_W'(seq_reg);
    assign base_out_ext = EXT_W'(base_next);

    always_comb
    begin
        res_next.status      = status_reg;
        res_next.ack_valid   = ack_reg;
        res_next.ack_seq     = ack_reg ? seq_out_ext[15:0] : 16'd0;
        res_next.window_base = base_out_ext[15:0];
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            head_reg <= '0;
            mark_reg <= '0;
        end
        else if (cmd.eval)
        begin
            mark_reg <= mark_set;
        end
        else if (cmd.commit)
        begin
            mark_reg <= mark_slid;
            base_reg <= base_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            seq_reg <= seq_in_ext[SEQ_BITS-1:0];
            val_reg <= pkt.payload;
        end
        if (cmd.eval)
        begin
            status_reg <= status_next;
            ack_reg    <= ack_next;
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval && store_new)
        begin
            slot_mem[wr_idx] <= val_reg;
        end
    end

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for selective_repeat_receive_window
// depends on srrw_pkg and the rtl of the block, nothing else
// a predictor of the receive window checks every result beat in order
module tb;

    import srrw_pkg::*;

    localparam int WIN        = WINDOW_DEF;
    localparam int QUIET_MAX  = 4000;  // cycles with no beat on either side
    localparam int SHOW_MAX   = 10;    // mismatches printed in full

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pkt_valid = 1'b0;
    logic pkt_ready;
    pkt_t pkt = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    // idling knobs, percent of cycles
    int send_idle_pct = 0;
    int res_stall_pct = 0;

    // predicted window state; stored payloads never reach a result,
    // so only the received marks and the base are tracked
    logic [15:0] win_base = '0;
    logic        win_mark [WIN];

    res_t expected_results [$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int packets_sent = 0;
    int results_seen = 0;
    int cnt_new = 0;
    int cnt_dup = 0;
    int cnt_out = 0;

    selective_repeat_receive_window #(
        .WINDOW   (WIN),
        .SEQ_BITS (SEQ_BITS_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // 2 time unit clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor: one packet beat in, one result beat out, window state updated
    function automatic res_t predict_arrival(input pkt_t beat);
        logic [15:0] ahead;
        logic [15:0] behind;
        res_t        r;
        int          k;
        int          j;
        ahead  = beat.seq_number - win_base;
        behind = win_base - beat.seq_number;
        r = '0;
        if (ahead < WIN)
        begin
            // inside the current window: store or flag a duplicate, then slide
            if (!win_mark[ahead])
            begin
                win_mark[ahead] = 1'b1;
                r.status = ST_NEW;
            end
            else
                r.status = ST_DUP;
            r.ack_valid = 1'b1;
            for (k = 0; k < WIN; k++)
            begin
                if (win_mark[0])
                begin
                    for (j = 0; j + 1 < WIN; j++)
                        win_mark[j] = win_mark[j + 1];
                    win_mark[WIN - 1] = 1'b0;
                    win_base = win_base + 16'd1;
                end
            end
        end
        else if (behind >= 1 && behind <= WIN)
        begin
            // already delivered: ack again so a lost ack cannot stall the sender
            r.status = ST_DUP;
            r.ack_valid = 1'b1;
        end
        else
            r.status = ST_OUT;
        if (r.ack_valid)
            r.ack_seq = beat.seq_number;
        r.window_base = win_base;
        case (r.status)
            ST_NEW:  cnt_new++;
            ST_DUP:  cnt_dup++;
            default: cnt_out++;
        endcase
        return r;
    endfunction

    // send one packet beat; idle gaps are drawn at the falling edge before
    // valid goes up, then valid holds until the rising edge that takes it
    task automatic send_packet(input logic [15:0] seq, input logic [31:0] value);
        pkt_t beat;
        beat.seq_number = seq;
        beat.payload    = value;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pkt_valid <= 1'b0;
            @(negedge clk);
        end
        pkt       <= beat;
        pkt_valid <= 1'b1;
        do
            @(posedge clk);
        while (!pkt_ready);
        expected_results.push_back(predict_arrival(beat));
        packets_sent++;
    endtask

    // sender holds off until every predicted result has been taken
    task automatic wait_drained();
        @(negedge clk);
        pkt_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // random payload with the sign extremes and bit patterns mixed in
    function automatic logic [31:0] pick_payload();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly packets that move the window, some resends and some noise
    task automatic send_random_packets(input int count);
        int          n;
        int          pick;
        logic [15:0] seq;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
                seq = win_base;
            else if (pick < 55)
                seq = win_base + 16'($urandom_range(1, WIN - 1));
            else if (pick < 70)
                seq = win_base - 16'($urandom_range(1, WIN));
            else if (pick < 75)
                seq = win_base + 16'(WIN);
            else if (pick < 80)
                seq = win_base - 16'(WIN + 1);
            else
                seq = 16'($urandom);
            send_packet(seq, pick_payload());
        end
    endtask

    // window edges, both windows, far packets, full slides, payload extremes
    task automatic test_window_edges();
        send_idle_pct = 0;
        res_stall_pct = 0;
        send_packet(16'd0, 32'h7FFF_FFFF);      // base slot, slide by one
        send_packet(16'd0, 32'h0000_0000);      // just delivered: previous window
        send_packet(16'd2, 32'h8000_0000);      // stored out of order
        send_packet(16'd2, 32'hFFFF_FFFF);      // duplicate inside the window
        send_packet(16'd4, 32'h5555_5555);      // top slot of the window
        send_packet(16'd5, 32'hAAAA_AAAA);      // one past the top
        send_packet(16'hFFFF, 32'h0000_0001);   // previous window across the wrap
        send_packet(16'hFFFD, 32'h0000_0000);   // far edge of the previous window
        send_packet(16'hFFFC, 32'h0000_0000);   // one past it
        send_packet(16'h8001, 32'h1234_5678);   // half the sequence space away
        send_packet(16'd1, 32'h0F0F_F0F0);      // fills the gap, slides two
        send_packet(16'd3, 32'hF0F0_0F0F);      // slides past the stored top
        send_packet(16'd9, 32'h0000_0002);      // one past the top again
        send_packet(16'd8, 32'h0000_0003);      // fill from the top down
        send_packet(16'd7, 32'h0000_0004);
        send_packet(16'd6, 32'h0000_0005);
        send_packet(16'd5, 32'h0000_0006);      // whole window slides at once
        send_packet(16'd1, 32'h0000_0007);      // well behind: discarded
        wait_drained();
    endtask

    // random traffic through the idling phases, draining between them
    task automatic test_random_traffic();
        send_idle_pct = 0;
        res_stall_pct = 0;
        send_random_packets(125);
        wait_drained();
        send_idle_pct = 61;
        res_stall_pct = 0;
        send_random_packets(125);
        wait_drained();
        send_idle_pct = 0;
        res_stall_pct = 61;
        send_random_packets(125);
        wait_drained();
        send_idle_pct = 17;
        res_stall_pct = 17;
        send_random_packets(125);
        wait_drained();
    endtask

    // walk the base forward in shuffled blocks of a full window,
    // then random traffic with both sides idling
    task automatic test_block_walk();
        int          order [WIN];
        int          b;
        int          k;
        int          r;
        int          tmp;
        logic [15:0] block_base;
        send_idle_pct = 0;
        res_stall_pct = 0;
        for (b = 0; b < 30; b++)
        begin
            block_base = win_base;
            for (k = 0; k < WIN; k++)
                order[k] = k;
            for (k = WIN - 1; k > 0; k--)
            begin
                r = $urandom_range(k);
                tmp = order[k];
                order[k] = order[r];
                order[r] = tmp;
            end
            for (k = 0; k < WIN; k++)
                send_packet(block_base + 16'(order[k]), $urandom);
        end
        wait_drained();
        send_idle_pct = 17;
        res_stall_pct = 17;
        send_random_packets(80);
        wait_drained();
    endtask

    // result side: random stalls, changed only at the falling edge
    always @(negedge clk)
        res_ready <= ($urandom_range(99) >= res_stall_pct);

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result beat: status %0d ack %0b seq %h base %h",
                             res.status, res.ack_valid, res.ack_seq, res.window_base);
            end
            else
            begin
                want = expected_results.pop_front();
                if (res.status !== want.status || res.ack_valid !== want.ack_valid ||
                    res.ack_seq !== want.ack_seq || res.window_base !== want.window_base)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("result %0d: expected status %0d ack %0b seq %h base %h, got status %0d ack %0b seq %h base %h",
                                 results_seen, want.status, want.ack_valid, want.ack_seq,
                                 want.window_base, res.status, res.ack_valid, res.ack_seq,
                                 res.window_base);
                end
            end
        end
    end

    // watchdog: ends the run once no beat has moved for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pkt_valid && pkt_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         QUIET_MAX, expected_results.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        for (k = 0; k < WIN; k++)
            win_mark[k] = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_window_edges();
        test_random_traffic();
        test_block_walk();

        // anything still predicted after the final drain is a lost result
        if (expected_results.size() != 0)
            mismatches++;

        $display("%0d packets, %0d results: %0d stored, %0d duplicate, %0d discarded",
                 packets_sent, results_seen, cnt_new, cnt_dup, cnt_out);
        $display("window edges, idling phases and block walk done, base ended at %h; %0d mismatches",
                 win_base, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
